// ----- rtl/gpht_pkg.sv -----
// Package for the grouped probe hash table: word types, codes and constants.
// No dependencies.
`default_nettype none
package gpht_pkg;
   typedef struct packed {
      logic [1:0]  action;
      logic [63:0] key;
      logic [63:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [63:0] value_out;
      logic [10:0] live_entries;
   } rsp_type;

   localparam logic [1:0] ACT_LOOKUP = 2'd0;
   localparam logic [1:0] ACT_INSERT = 2'd1;
   localparam logic [1:0] ACT_GETDEF = 2'd2;
   localparam logic [1:0] ACT_ERASE  = 2'd3;

   localparam logic [1:0] ST_FOUND    = 2'd0;
   localparam logic [1:0] ST_INSERTED = 2'd1;
   localparam logic [1:0] ST_MISSING  = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   localparam logic [7:0]  CTRL_EMPTY = 8'h80;
   localparam logic [7:0]  CTRL_TOMB  = 8'hFE;
   localparam logic [63:0] MIX_MULT   = 64'hd6e8feb86659fd93;
   localparam logic [10:0] MAX_LIVE_RESET = 11'd896;
endpackage
`default_nettype wire

// ----- rtl/gpht_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module gpht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ----- rtl/gpht_mixer.sv -----
// Key mixer: xor-shift, 64-bit multiply in three 32x32 partial products, xor-shift.
// Uses gpht_pkg. Hash valid (done high) after the x_ff and product registers; pipelined.
`default_nettype none
module gpht_mixer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] key,
   output logic             done,
   output logic [63:0]      hash
);
   import gpht_pkg::*;

   logic [63:0] x_ff, x_in;
   logic [63:0] lo_ff, lo_in;
   logic [31:0] c1_ff, c1_in, c2_ff, c2_in;
   logic [1:0]  stage_ff, stage_in;
   logic [63:0] prod;

   always_comb begin
      x_in  = x_ff;
      lo_in = lo_ff;
      c1_in = c1_ff;
      c2_in = c2_ff;
      stage_in = {stage_ff[0], start};
      if (start) x_in = key ^ {32'd0, key[63:32]};
      if (stage_ff[0]) begin
         lo_in = 64'(x_ff[31:0]) * 64'(MIX_MULT[31:0]);
         c1_in = x_ff[31:0] * MIX_MULT[63:32];
         c2_in = x_ff[63:32] * MIX_MULT[31:0];
      end
   end

   assign prod = lo_ff + {c1_ff + c2_ff, 32'd0};
   assign hash = prod ^ {32'd0, prod[63:32]};
   assign done = stage_ff[1];

   always_ff @(posedge clock) begin
      if (reset) stage_ff <= '0;
      else stage_ff <= stage_in;
      x_ff  <= x_in;
      lo_ff <= lo_in;
      c1_ff <= c1_in;
      c2_ff <= c2_in;
   end
endmodule
`default_nettype wire

// ----- rtl/grouped_probe_hash_table.sv -----
// Top level of the grouped probe hash table: probe sequencer and stores.
// Uses gpht_pkg, gpht_mixer, gpht_ram.
//
//   port group   dir  handshake          word
//   req_         in   req_valid/req_stall req_type
//   rsp_         out  rsp_valid/rsp_stall rsp_type
//   csr_         in   csr_wr_en          max_live
//
// After the accept edge the reply follows the key mixing, a tag read and key compare per
// slot scanned (only the tag read for an empty tag), and the final write.
// After reset a clearing pass writes the empty tag to every slot, one slot a
// cycle; no word is taken meanwhile.
// The result register holds under rsp_stall; no word is taken while it waits.
`default_nettype none
module grouped_probe_hash_table #(
   parameter int GROUP_SLOTS = 16,
   parameter int GROUP_COUNT = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire gpht_pkg::req_type req_word,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output gpht_pkg::rsp_type      rsp_word,
   input  wire logic              csr_wr_en,
   input  wire logic [10:0]       csr_wr_data
);
   import gpht_pkg::*;

   localparam int SLOTS = GROUP_SLOTS * GROUP_COUNT;
   localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int SW = (GROUP_SLOTS > 1) ? $clog2(GROUP_SLOTS) : 1;
   localparam int GW = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
   localparam int CW = $clog2(SLOTS + 1);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_MIX   = 3'd2;
   localparam logic [2:0] S_TAG   = 3'd3;
   localparam logic [2:0] S_KEY   = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;
   localparam logic [2:0] S_OUT   = 3'd6;

   logic [2:0]    state_ff, state_in;
   req_type       req_ff, req_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [CW-1:0] scanned_ff, scanned_in;
   logic [6:0]    tag_ff, tag_in;
   logic [10:0]   live_ff, live_in, occ_ff, occ_in, max_ff, max_in;
   logic          hit_ff, hit_in, hole_ff, hole_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   logic          mix_done;
   logic [63:0]   hash;
   logic [7:0]    tag_rd;
   logic [63:0]   key_rd, val_rd;
   logic          tag_we, key_we, val_we;
   logic [7:0]    tag_wd;
   logic [63:0]   val_wd;
   logic [AW-1:0] next_addr, start_addr;
   logic [GW-1:0] start_group;
   logic          accept;

   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE) || (rsp_valid_ff && rsp_stall);
   assign start_group = GW'((hash >> 7) % GROUP_COUNT);
   assign start_addr = AW'(start_group * GROUP_SLOTS);
   assign next_addr = (32'(addr_ff) == SLOTS - 1) ? '0 : addr_ff + 1'b1;

   gpht_mixer u_mixer (
      .clock, .reset, .start(accept), .key(req_word.key), .done(mix_done), .hash(hash)
   );

   gpht_ram #(.WIDTH(8), .DEPTH(SLOTS)) u_tags (
      .clock, .wr_en(tag_we), .wr_addr(addr_ff), .wr_data(tag_wd),
      .rd_addr(addr_in), .rd_data(tag_rd)
   );
   gpht_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_keys (
      .clock, .wr_en(key_we), .wr_addr(addr_ff), .wr_data(req_ff.key),
      .rd_addr(addr_in), .rd_data(key_rd)
   );
   gpht_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_vals (
      .clock, .wr_en(val_we), .wr_addr(addr_ff), .wr_data(val_wd),
      .rd_addr(addr_in), .rd_data(val_rd)
   );

   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      addr_in = addr_ff;
      scanned_in = scanned_ff;
      tag_in = tag_ff;
      live_in = live_ff;
      occ_in = occ_ff;
      max_in = csr_wr_en ? csr_wr_data : max_ff;
      hit_in = hit_ff;
      hole_in = hole_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in = rsp_ff;
      tag_we = 1'b0;
      key_we = 1'b0;
      val_we = 1'b0;
      tag_wd = CTRL_EMPTY;
      val_wd = req_ff.value;
      case (state_ff)
         S_CLEAR: begin
            tag_we = 1'b1;
            addr_in = next_addr;
            if (32'(addr_ff) == SLOTS - 1) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               req_in = req_word;
               state_in = S_MIX;
            end
         end
         S_MIX: begin
            if (mix_done) begin
               addr_in = start_addr;
               tag_in = hash[6:0];
               scanned_in = '0;
               hit_in = 1'b0;
               hole_in = 1'b0;
               state_in = S_TAG;
            end
         end
         S_TAG: begin
            if (tag_rd == CTRL_EMPTY) begin
               hole_in = 1'b1;
               state_in = S_DONE;
            end else begin
               state_in = S_KEY;
            end
         end
         S_KEY: begin
            if (tag_rd == {1'b0, tag_ff} && key_rd == req_ff.key) begin
               hit_in = 1'b1;
               state_in = S_DONE;
            end else if (32'(scanned_ff) == SLOTS - 1) begin
               state_in = S_DONE;
            end else begin
               scanned_in = scanned_ff + 1'b1;
               addr_in = next_addr;
               state_in = S_TAG;
            end
         end
         S_DONE: begin
            rsp_in.status = ST_MISSING;
            rsp_in.value_out = '0;
            if (hit_ff) begin
               rsp_in.status = ST_FOUND;
               rsp_in.value_out = val_rd;
               if (req_ff.action == ACT_INSERT) begin
                  val_we = 1'b1;
                  rsp_in.value_out = req_ff.value;
               end
               if (req_ff.action == ACT_ERASE) begin
                  tag_we = 1'b1;
                  tag_wd = CTRL_TOMB;
                  live_in = live_ff - 1'b1;
               end
            end else if (req_ff.action == ACT_INSERT || req_ff.action == ACT_GETDEF) begin
               if (!hole_ff || 12'(live_ff) + 12'd1 > 12'(max_ff)) begin
                  rsp_in.status = ST_FULL;
               end else begin
                  if (req_ff.action == ACT_GETDEF) val_wd = '0;
                  tag_we = 1'b1;
                  tag_wd = {1'b0, tag_ff};
                  key_we = 1'b1;
                  val_we = 1'b1;
                  live_in = live_ff + 1'b1;
                  occ_in = occ_ff + 1'b1;
                  rsp_in.status = ST_INSERTED;
                  rsp_in.value_out = val_wd;
               end
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            rsp_in.live_entries = live_ff;
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         addr_ff <= '0;
         live_ff <= '0;
         occ_ff <= '0;
         max_ff <= MAX_LIVE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         addr_ff <= addr_in;
         live_ff <= live_in;
         occ_ff <= occ_in;
         max_ff <= max_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff <= req_in;
      scanned_ff <= scanned_in;
      tag_ff <= tag_in;
      hit_ff <= hit_in;
      hole_ff <= hole_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word = rsp_ff;

   a_live_le_occ: assert property (@(posedge clock) disable iff (reset)
      live_ff <= occ_ff) else $error("live count above occupied count");
   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !accept) else $error("word taken during clear");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("result lost under stall");
endmodule
`default_nettype wire

// ----- test/tb_grouped_probe_hash_table.sv -----
// Testbench for grouped_probe_hash_table: random and directed table actions, with
// a scoreboard that predicts every reply. Depends on gpht_pkg and the block's RTL.
`default_nettype none
module tb_grouped_probe_hash_table;
   import gpht_pkg::*;

   localparam int SLOTS = 16;
   localparam int GROUPS = 64;
   localparam int TABLE = SLOTS * GROUPS;
   localparam longint CYCLE_LIMIT = 20000000;

   class table_scoreboard;
      bit [7:0]  tags[TABLE];
      bit [63:0] keys[TABLE];
      bit [63:0] vals[TABLE];
      int unsigned live;
      int unsigned occupied;
      bit [10:0] max_live;
      rsp_type   pending[$];
      int        errors;

      function new();
         foreach (tags[i]) tags[i] = CTRL_EMPTY;
         live = 0;
         occupied = 0;
         max_live = MAX_LIVE_RESET;
         errors = 0;
      endfunction

      function bit [63:0] mix(bit [63:0] x);
         x ^= x >> 32;
         x *= MIX_MULT;
         x ^= x >> 32;
         return x;
      endfunction

      function void note_request(req_type r);
         bit [63:0] h;
         bit [7:0]  tag;
         int        g, s, hit, hole;
         rsp_type   e;
         h = mix(r.key);
         tag = {1'b0, h[6:0]};
         g = h[12:7];
         hit = -1;
         hole = -1;
         for (int n = 0; n < GROUPS && hit < 0 && hole < 0; n++) begin
            for (int i = 0; i < SLOTS; i++) begin
               s = g * SLOTS + i;
               if (tags[s] == tag && keys[s] == r.key) begin
                  hit = s;
                  break;
               end
               if (tags[s] == CTRL_EMPTY) begin
                  hole = s;
                  break;
               end
            end
            g = (g + 1) % GROUPS;
         end
         e.status = ST_MISSING;
         e.value_out = '0;
         if (hit >= 0) begin
            if (r.action == ACT_INSERT) vals[hit] = r.value;
            e.value_out = vals[hit];
            if (r.action == ACT_ERASE) begin
               tags[hit] = CTRL_TOMB;
               live--;
            end
            e.status = ST_FOUND;
         end else if (r.action == ACT_INSERT || r.action == ACT_GETDEF) begin
            if (hole < 0 || live + 1 > max_live) begin
               e.status = ST_FULL;
            end else begin
               tags[hole] = tag;
               keys[hole] = r.key;
               vals[hole] = (r.action == ACT_INSERT) ? r.value : 64'd0;
               live++;
               occupied++;
               e.value_out = vals[hole];
               e.status = ST_INSERTED;
            end
         end
         e.live_entries = live[10:0];
         pending.push_back(e);
      endfunction

      function void check_reply(rsp_type r);
         rsp_type e;
         if (pending.size() == 0) begin
            $error("unexpected reply word %h", r);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (r.status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, r.status);
            errors++;
         end
         if (r.value_out !== e.value_out) begin
            $error("value_out: expected %h, got %h", e.value_out, r.value_out);
            errors++;
         end
         if (r.live_entries !== e.live_entries) begin
            $error("live_entries: expected %0d, got %0d", e.live_entries, r.live_entries);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   req_type     req_word = '0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   rsp_type     rsp_word;
   logic        csr_wr_en = 0;
   logic [10:0] csr_wr_data = '0;

   table_scoreboard sb = new();
   int     send_idle_pct = 0;
   int     recv_stall_pct = 0;
   int     hold_left = 0;
   longint cycles = 0;
   bit [63:0] key_pool[48];
   bit [63:0] live_keys[$];

   grouped_probe_hash_table dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_reply(rsp_word);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic bit [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic send(logic [1:0] act, bit [63:0] k, bit [63:0] v);
      req_type r;
      r.action = act;
      r.key = k;
      r.value = v;
      if ($urandom_range(99) < send_idle_pct) begin
         repeat ($urandom_range(4, 1)) begin
            @(negedge clock);
            req_valid <= 1'b0;
            req_word <= {2'($urandom), rand64(), rand64()};
         end
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_word <= r;
      do @(posedge clock); while (req_stall);
      sb.note_request(r);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_max_live(logic [10:0] v);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      sb.max_live = v;
   endtask

   task automatic random_phase(int n, logic [10:0] cap, int sp, int rp);
      bit [63:0] k, v;
      write_max_live(cap);
      send_idle_pct = sp;
      recv_stall_pct = rp;
      foreach (key_pool[i]) key_pool[i] = rand64();
      for (int i = 0; i < n; i++) begin
         k = ($urandom_range(9) < 8) ? key_pool[$urandom_range(47)] : rand64();
         case ($urandom_range(7))
            0: v = '0;
            1: v = '1;
            default: v = rand64();
         endcase
         send(2'($urandom_range(3)), k, v);
      end
   endtask

   initial begin
      bit [63:0] k;
      int j;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: every action, key and value extremes, tombstones, live limit
      send(ACT_LOOKUP, 64'd0, 64'd0);
      send(ACT_ERASE, 64'd0, 64'd0);
      send(ACT_INSERT, 64'd0, '1);
      send(ACT_INSERT, 64'd0, 64'd0);
      send(ACT_GETDEF, '1, '1);
      send(ACT_GETDEF, 64'd0, 64'd5);
      send(ACT_LOOKUP, '1, 64'd0);
      send(ACT_ERASE, 64'd0, 64'd0);
      send(ACT_LOOKUP, 64'd0, 64'd0);
      send(ACT_ERASE, 64'd0, 64'd0);
      send(ACT_INSERT, 64'd0, 64'h5555_aaaa_5555_aaaa);
      send(ACT_INSERT, 64'h8000_0000_0000_0000, 64'h1);
      write_max_live(11'd1);
      send(ACT_INSERT, 64'h1234, 64'h1);
      send(ACT_GETDEF, 64'h1234, 64'h1);
      send(ACT_INSERT, 64'd0, '1);
      send(ACT_ERASE, '1, 64'd0);
      send(ACT_ERASE, 64'h8000_0000_0000_0000, 64'd0);
      send(ACT_INSERT, 64'h1234, 64'h2);
      write_max_live(11'd0);
      send(ACT_GETDEF, 64'h99, 64'd0);
      send(ACT_LOOKUP, 64'd0, 64'd0);
      send(ACT_ERASE, 64'd0, 64'd0);
      send(ACT_INSERT, 64'h99, 64'h7);

      random_phase(60, 11'd1024, 0, 0);
      random_phase(60, 11'd5, 77, 0);
      drain();
      hold_left = 400;
      random_phase(60, 11'd2047, 0, 77);
      random_phase(60, 11'd40, 22, 22);
      random_phase(60, MAX_LIVE_RESET, 0, 0);

      // fill every slot, then probe a table with no empty slot
      write_max_live(11'd1024);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      while (sb.occupied < TABLE) begin
         if ($urandom_range(19) == 0 && live_keys.size() > 0) begin
            j = $urandom_range(live_keys.size() - 1);
            send(ACT_ERASE, live_keys[j], 64'd0);
            live_keys.delete(j);
         end else begin
            k = rand64();
            send(ACT_INSERT, k, rand64());
            live_keys.push_back(k);
         end
      end
      send(ACT_LOOKUP, rand64(), 64'd0);
      send(ACT_ERASE, rand64(), 64'd0);
      send(ACT_INSERT, rand64(), rand64());
      send(ACT_GETDEF, rand64(), 64'd0);
      send(ACT_LOOKUP, live_keys[0], 64'd0);
      send(ACT_INSERT, live_keys[0], '1);

      drain();
      repeat (20) @(posedge clock);
      if (sb.errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end
endmodule
`default_nettype wire
